/* rtl/lrrsa_pkg.sv */
// ----------------------------------------------------------------------------
// lrrsa_pkg
// Types and codes shared by the locked round-robin switch allocator.
// ----------------------------------------------------------------------------
package lrrsa_pkg;

    localparam int FIELD_W = 3;

    typedef logic [FIELD_W-1:0] field_t;

    localparam field_t OP_REQUEST   = 3'd0;
    localparam field_t OP_PICK      = 3'd1;
    localparam field_t OP_CLEAR_WIN = 3'd2;
    localparam field_t OP_CLEAR_REQ = 3'd3;
    localparam field_t OP_PROBE     = 3'd4;

    typedef struct packed {
        field_t req_type;
        field_t out_port;
        field_t in_port;
    } item_t;

    typedef struct packed {
        logic   grant_valid;
        field_t winner_port;
        logic   no_winner_error;
        logic   request_bit;
        logic   all_empty;
    } result_t;

endpackage

/* rtl/locked_round_robin_switch_allocator_unit.sv */
// ----------------------------------------------------------------------------
// locked_round_robin_switch_allocator_unit
// Per-output-port switch allocator with packet lock and round-robin grant.
// ----------------------------------------------------------------------------
// The edge that accepts an item reads the request row and the pointer of the
// addressed output port from their memories into registers, busy is high in
// ST_EXEC, and the edge that ends it writes the row and pointer back and
// loads the result, which shows with strobe high while a new item may
// already be accepted. The registered read of the memories sets this split.
// Results cannot be held off, so sample result whenever strobe is high.
// Reset takes effect at once: per-row valid flops stand in for a clearing
// pass.
module locked_round_robin_switch_allocator_unit #(
    parameter int NUM_PORTS = 5
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lrrsa_pkg::item_t  item,
    output logic              strobe,
    output lrrsa_pkg::result_t result
);

    localparam int PORT_W = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_PORTS-1:0] req_mem [NUM_PORTS];
    logic [PORT_W-1:0]    hold_mem [NUM_PORTS];

    logic [NUM_PORTS-1:0] req_rd_reg;
    logic [PORT_W-1:0]    hold_rd_reg;
    lrrsa_pkg::item_t     item_reg;

    logic [NUM_PORTS-1:0] row_nz_reg, row_nz_next;
    logic [NUM_PORTS-1:0] ptr_vld_reg, ptr_vld_next;
    logic [NUM_PORTS-1:0] done_reg, done_next;
    logic [NUM_PORTS-1:0] lock_reg, lock_next;

    lrrsa_pkg::result_t   result_reg, result_next;
    logic                 strobe_reg, strobe_next;

    logic                 accept;
    logic [PORT_W-1:0]    rd_addr;
    logic                 o_ok, i_ok;
    logic [PORT_W-1:0]    oidx, iidx;
    logic [NUM_PORTS-1:0] row, row_new, ibit;
    logic [PORT_W-1:0]    ptr;
    logic                 pick_found;
    logic [PORT_W-1:0]    pick_idx;
    logic                 row_we, hold_we;
    logic [PORT_W-1:0]    winner;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg == ST_EXEC);
    assign strobe  = strobe_reg;
    assign result  = result_reg;
    assign rd_addr = (32'(item.out_port) < NUM_PORTS) ? PORT_W'(item.out_port) : '0;

    // Memory read port
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_rd_reg  <= req_mem[rd_addr];
            hold_rd_reg <= hold_mem[rd_addr];
            item_reg    <= item;
        end
    end

    // Memory write port
    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            req_mem[oidx] <= row_new;
        end
        if (hold_we)
        begin
            hold_mem[oidx] <= pick_idx;
        end
    end

    assign o_ok = 32'(item_reg.out_port) < NUM_PORTS;
    assign i_ok = 32'(item_reg.in_port) < NUM_PORTS;
    assign oidx = o_ok ? PORT_W'(item_reg.out_port) : '0;
    assign iidx = i_ok ? PORT_W'(item_reg.in_port) : '0;
    assign row  = row_nz_reg[oidx] ? req_rd_reg : '0;
    assign ptr  = ptr_vld_reg[oidx] ? hold_rd_reg : '0;
    assign ibit = {{(NUM_PORTS-1){1'b0}}, 1'b1} << iidx;

    lrrsa_rr_pick #(
        .NUM_PORTS (NUM_PORTS),
        .PORT_W    (PORT_W)
    ) u_pick (
        .row   (row),
        .ptr   (ptr),
        .found (pick_found),
        .idx   (pick_idx)
    );

    always_comb
    begin
        state_next   = state_reg;
        row_nz_next  = row_nz_reg;
        ptr_vld_next = ptr_vld_reg;
        done_next    = done_reg;
        lock_next    = lock_reg;
        result_next  = result_reg;
        strobe_next  = 1'b0;
        row_new      = row;
        row_we       = 1'b0;
        hold_we      = 1'b0;
        winner       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
                strobe_next = 1'b1;
                result_next = '0;
                result_next.request_bit = o_ok && i_ok && row[iidx];

                if (item_reg.req_type == lrrsa_pkg::OP_PICK)
                begin
                    if (o_ok)
                    begin
                        if (done_reg[oidx] || lock_reg[oidx])
                        begin
                            done_next[oidx] = 1'b1;
                            result_next.grant_valid = 1'b1;
                            winner = ptr;
                        end
                        else if (pick_found)
                        begin
                            done_next[oidx] = 1'b1;
                            lock_next[oidx] = 1'b1;
                            hold_we = 1'b1;
                            ptr_vld_next[oidx] = 1'b1;
                            result_next.grant_valid = 1'b1;
                            winner = pick_idx;
                        end
                        else
                        begin
                            result_next.no_winner_error = 1'b1;
                        end
                    end
                end
                else if (o_ok && i_ok)
                begin
                    case (item_reg.req_type)
                        lrrsa_pkg::OP_REQUEST:
                        begin
                            row_new = row | ibit;
                            row_we = 1'b1;
                            done_next[oidx] = 1'b0;
                        end
                        lrrsa_pkg::OP_CLEAR_WIN:
                        begin
                            row_new = row & ~ibit;
                            row_we = 1'b1;
                            done_next[oidx] = 1'b0;
                            lock_next[oidx] = 1'b0;
                        end
                        lrrsa_pkg::OP_CLEAR_REQ:
                        begin
                            row_new = row & ~ibit;
                            row_we = 1'b1;
                        end
                        default:
                        begin
                            row_we = 1'b0;
                        end
                    endcase
                end

                if (row_we)
                begin
                    row_nz_next[oidx] = |row_new;
                end
                result_next.winner_port = lrrsa_pkg::FIELD_W'(winner);
                result_next.all_empty = ~|row_nz_next;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            row_nz_reg  <= '0;
            ptr_vld_reg <= '0;
            done_reg    <= '0;
            lock_reg    <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            row_nz_reg  <= row_nz_next;
            ptr_vld_reg <= ptr_vld_next;
            done_reg    <= done_next;
            lock_reg    <= lock_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

/* rtl/lrrsa_rr_pick.sv */
// ----------------------------------------------------------------------------
// lrrsa_rr_pick
// Round-robin priority encoder: first set bit after the pointer, wrapping,
// the pointer position itself taken last.
// ----------------------------------------------------------------------------
module lrrsa_rr_pick #(
    parameter int NUM_PORTS = 5,
    parameter int PORT_W    = 3
) (
    input  logic [NUM_PORTS-1:0] row,
    input  logic [PORT_W-1:0]    ptr,
    output logic                 found,
    output logic [PORT_W-1:0]    idx
);

    logic [NUM_PORTS-1:0] masked;
    logic [PORT_W-1:0]    idx_hi;
    logic [PORT_W-1:0]    idx_lo;

    always_comb
    begin
        for (int i = 0; i < NUM_PORTS; i++)
        begin
            masked[i] = row[i] && (PORT_W'(i) > ptr);
        end
    end

    always_comb
    begin
        idx_hi = '0;
        idx_lo = '0;
        for (int i = NUM_PORTS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                idx_hi = PORT_W'(i);
            end
            if (row[i])
            begin
                idx_lo = PORT_W'(i);
            end
        end
    end

    assign found = |row;
    assign idx   = (|masked) ? idx_hi : idx_lo;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the locked round-robin switch allocator. Items go
// in through the start/busy handshake and a predictor of the allocator state
// (request rows, done and lock flags, round-robin pointers, held winners)
// works out each result. Every strobed result is compared against the
// oldest prediction. A short run of directed cases comes first, then random
// request/pick/release traffic under several sender idle rates.
// ----------------------------------------------------------------------------
module tb;

    localparam int PORTS = 5;

    localparam lrrsa_pkg::field_t OP_SPARE_0 = 3'd5;
    localparam lrrsa_pkg::field_t OP_SPARE_1 = 3'd6;
    localparam lrrsa_pkg::field_t OP_SPARE_2 = 3'd7;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    lrrsa_pkg::item_t   item = '0;
    logic               strobe;
    lrrsa_pkg::result_t result;

    logic [PORTS-1:0]  req_rows [PORTS];
    logic [PORTS-1:0]  done_mask;
    logic [PORTS-1:0]  lock_mask;
    lrrsa_pkg::field_t rr_ptr [PORTS];
    lrrsa_pkg::field_t held_win [PORTS];

    lrrsa_pkg::result_t grant_queue [$];
    int                 mismatches = 0;
    int                 idle_pct = 0;

    locked_round_robin_switch_allocator_unit #(
        .NUM_PORTS(PORTS)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .item  (item),
        .strobe(strobe),
        .result(result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic lrrsa_pkg::result_t predict_alloc(lrrsa_pkg::item_t it);
        lrrsa_pkg::result_t r;
        int      o;
        int      i;
        int      base;
        int      idx;
        logic    o_ok;
        logic    i_ok;
        logic    found;
        r = '0;
        o = it.out_port;
        i = it.in_port;
        o_ok = (o < PORTS);
        i_ok = (i < PORTS);
        found = 1'b0;
        if (o_ok && i_ok)
        begin
            r.request_bit = req_rows[o][i];
        end
        if (it.req_type == lrrsa_pkg::OP_PICK)
        begin
            if (o_ok)
            begin
                if (done_mask[o] || lock_mask[o])
                begin
                    done_mask[o] = 1'b1;
                    r.grant_valid = 1'b1;
                    r.winner_port = held_win[o];
                end
                else
                begin
                    base = rr_ptr[o];
                    for (int k = 1; k <= PORTS; k++)
                    begin
                        idx = (base + k) % PORTS;
                        if (!found && req_rows[o][idx])
                        begin
                            found = 1'b1;
                            rr_ptr[o] = lrrsa_pkg::field_t'(idx);
                            held_win[o] = lrrsa_pkg::field_t'(idx);
                        end
                    end
                    if (found)
                    begin
                        done_mask[o] = 1'b1;
                        lock_mask[o] = 1'b1;
                        r.grant_valid = 1'b1;
                        r.winner_port = held_win[o];
                    end
                    else
                    begin
                        r.no_winner_error = 1'b1;
                    end
                end
            end
        end
        else if (o_ok && i_ok)
        begin
            case (it.req_type)
                lrrsa_pkg::OP_REQUEST:
                begin
                    req_rows[o][i] = 1'b1;
                    done_mask[o] = 1'b0;
                end
                lrrsa_pkg::OP_CLEAR_WIN:
                begin
                    done_mask[o] = 1'b0;
                    lock_mask[o] = 1'b0;
                    req_rows[o][i] = 1'b0;
                end
                lrrsa_pkg::OP_CLEAR_REQ:
                begin
                    req_rows[o][i] = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        r.all_empty = 1'b1;
        for (int p = 0; p < PORTS; p++)
        begin
            if (req_rows[p] != '0)
            begin
                r.all_empty = 1'b0;
            end
        end
        return r;
    endfunction

    // Entered and left at a rising edge; start stays high unless a gap is drawn.
    task automatic send_item(input lrrsa_pkg::field_t op, input lrrsa_pkg::field_t op_out,
                             input lrrsa_pkg::field_t op_in);
        lrrsa_pkg::item_t it;
        it.req_type = op;
        it.out_port = op_out;
        it.in_port  = op_in;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        grant_queue.push_back(predict_alloc(it));
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        lrrsa_pkg::result_t want;
        if (rst_n && strobe)
        begin
            if (grant_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, result);
                mismatches++;
            end
            else
            begin
                want = grant_queue.pop_front();
                check_field("grant_valid", want.grant_valid, result.grant_valid);
                check_field("winner_port", want.winner_port, result.winner_port);
                check_field("no_winner_error", want.no_winner_error, result.no_winner_error);
                check_field("request_bit", want.request_bit, result.request_bit);
                check_field("all_empty", want.all_empty, result.all_empty);
            end
        end
    end

    task automatic apply_reset();
        for (int p = 0; p < PORTS; p++)
        begin
            req_rows[p] = '0;
            rr_ptr[p]   = '0;
            held_win[p] = '0;
        end
        done_mask = '0;
        lock_mask = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    task automatic test_out_of_range();
        send_item(lrrsa_pkg::OP_PROBE, 3'd0, 3'd0);
        send_item(lrrsa_pkg::OP_REQUEST, 3'd7, 3'd0);
        send_item(lrrsa_pkg::OP_REQUEST, 3'd0, 3'd7);
        send_item(lrrsa_pkg::OP_PICK, 3'd5, 3'd0);
        send_item(lrrsa_pkg::OP_CLEAR_WIN, 3'd6, 3'd3);
        send_item(lrrsa_pkg::OP_PROBE, 3'd7, 3'd7);
    endtask

    task automatic test_no_requester();
        send_item(lrrsa_pkg::OP_PICK, 3'd2, 3'd3);
        send_item(lrrsa_pkg::OP_PICK, 3'd2, 3'd7);
    endtask

    task automatic test_grant_and_lock();
        send_item(lrrsa_pkg::OP_REQUEST, 3'd1, 3'd2);
        send_item(lrrsa_pkg::OP_REQUEST, 3'd1, 3'd4);
        send_item(lrrsa_pkg::OP_PICK, 3'd1, 3'd0);
        send_item(lrrsa_pkg::OP_REQUEST, 3'd1, 3'd3);
        send_item(lrrsa_pkg::OP_PICK, 3'd1, 3'd6);
        send_item(lrrsa_pkg::OP_PROBE, 3'd1, 3'd2);
        send_item(lrrsa_pkg::OP_CLEAR_WIN, 3'd1, 3'd2);
        send_item(lrrsa_pkg::OP_PICK, 3'd1, 3'd0);
    endtask

    task automatic test_pointer_wrap();
        send_item(lrrsa_pkg::OP_REQUEST, 3'd4, 3'd0);
        send_item(lrrsa_pkg::OP_PICK, 3'd4, 3'd0);
        send_item(lrrsa_pkg::OP_CLEAR_WIN, 3'd4, 3'd0);
        send_item(lrrsa_pkg::OP_REQUEST, 3'd4, 3'd0);
        send_item(lrrsa_pkg::OP_PICK, 3'd4, 3'd5);
    endtask

    task automatic test_unused_ops();
        send_item(lrrsa_pkg::OP_CLEAR_REQ, 3'd1, 3'd4);
        send_item(OP_SPARE_0, 3'd1, 3'd3);
        send_item(OP_SPARE_1, 3'd3, 3'd1);
        send_item(OP_SPARE_2, 3'd0, 3'd0);
    endtask

    // Mostly request/pick/release sequences on one port, with noise mixed in.
    task automatic test_random_traffic(input int count, input int pct);
        int                n;
        lrrsa_pkg::field_t o;
        n = 0;
        idle_pct = pct;
        while (n < count)
        begin
            if ($urandom_range(9) < 2)
            begin
                send_item(lrrsa_pkg::field_t'($urandom_range(7)),
                          lrrsa_pkg::field_t'($urandom_range(7)),
                          lrrsa_pkg::field_t'($urandom_range(7)));
                n++;
            end
            else
            begin
                o = lrrsa_pkg::field_t'($urandom_range(PORTS - 1));
                repeat ($urandom_range(0, 3))
                begin
                    send_item(lrrsa_pkg::OP_REQUEST, o,
                              lrrsa_pkg::field_t'($urandom_range(PORTS - 1)));
                    n++;
                end
                repeat ($urandom_range(1, 2))
                begin
                    send_item(lrrsa_pkg::OP_PICK, o, lrrsa_pkg::field_t'($urandom_range(7)));
                    n++;
                end
                if ($urandom_range(3) != 0)
                begin
                    send_item(lrrsa_pkg::OP_CLEAR_WIN, o, held_win[o]);
                end
                else
                begin
                    send_item(lrrsa_pkg::OP_CLEAR_WIN, o,
                              lrrsa_pkg::field_t'($urandom_range(PORTS - 1)));
                end
                n++;
                if ($urandom_range(2) == 0)
                begin
                    send_item(lrrsa_pkg::OP_CLEAR_REQ, o,
                              lrrsa_pkg::field_t'($urandom_range(PORTS - 1)));
                    n++;
                end
                if ($urandom_range(3) == 0)
                begin
                    send_item(lrrsa_pkg::OP_PROBE, o,
                              lrrsa_pkg::field_t'($urandom_range(PORTS - 1)));
                    n++;
                end
            end
        end
    endtask

    initial
    begin
        apply_reset();
        test_out_of_range();
        test_no_requester();
        test_grant_and_lock();
        test_pointer_wrap();
        test_unused_ops();
        test_random_traffic(150, 0);
        test_random_traffic(130, 66);
        test_random_traffic(120, 33);
        test_random_traffic(100, 0);
        start <= 1'b0;
        while (grant_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/lrrsa_pkg.sv
rtl/lrrsa_rr_pick.sv
rtl/locked_round_robin_switch_allocator_unit.sv
tb/sv/tb.sv
